[design/sum_checked_frame_receiver_macros.svh]
// ---------------------------------------------------------------------------
// sum_checked_frame_receiver_macros
// assertion macros shared by the frame receiver modules
// ---------------------------------------------------------------------------
`ifndef SUM_CHECKED_FRAME_RECEIVER_MACROS_SVH
`define SUM_CHECKED_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/sfr_pkg.sv]
// ---------------------------------------------------------------------------
// sfr_pkg
// shared constants and types of the sum-checked frame receiver
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfr_pkg;

  // frame layout
  localparam int unsigned FRAME_LEN = 15;
  localparam int unsigned SUM_LAST  = 12;
  // cells hold bytes 1..13 at the moment byte 14 arrives
  localparam int unsigned CHAIN_LEN = FRAME_LEN - 2;

  localparam int unsigned IDX_W = 4;
  localparam int unsigned SUM_W = 12;
  localparam int unsigned CHK_W = 16;

  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_SUM   = IDX_W'(SUM_LAST);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(FRAME_LEN - 1);

  // register reset values
  localparam logic [7:0] HEADER_RST = 8'hAC;
  localparam logic [7:0] TYPE_RST   = 8'h03;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER = 1'b0,
    CFG_TYPE   = 1'b1
  } cfg_idx_t;

  typedef logic [CHAIN_LEN-1:0][7:0] byte_row_t;

  // control from the sequencer to the cell row and the output stage
  typedef struct packed {
    logic shift;
    logic emit;
  } sfr_ctrl_t;

endpackage

[design/sfr_cell.sv]
// ---------------------------------------------------------------------------
// sfr_cell
// one byte cell of the frame row, loads its neighbor's byte on shift
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_cell (
  input  logic       clk,
  input  logic       shift_i,
  input  logic [7:0] d_i,
  output logic [7:0] q_o
);

  logic [7:0] byte_r;

  // payload storage, no reset needed
  always_ff @(posedge clk) begin
    if (shift_i) begin
      byte_r <= d_i;
    end
  end

  assign q_o = byte_r;

endmodule

[design/sfr_chain.sv]
// ---------------------------------------------------------------------------
// sfr_chain
// row of byte cells, newest byte in cell 0, each cell feeds the next
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfr_chain (
  input  logic              clk,
  input  logic              shift_i,
  input  logic [7:0]        byte_i,
  output sfr_pkg::byte_row_t taps_o
);

  import sfr_pkg::*;

  byte_row_t q;

  // cell 0 takes the incoming byte, the rest take their left neighbor
  for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_cell
    if (k == 0) begin : g_head
      sfr_cell u_cell (
        .clk     (clk),
        .shift_i (shift_i),
        .d_i     (byte_i),
        .q_o     (q[k])
      );
    end else begin : g_body
      sfr_cell u_cell (
        .clk     (clk),
        .shift_i (shift_i),
        .d_i     (q[k-1]),
        .q_o     (q[k])
      );
    end
  end

  assign taps_o = q;

endmodule

[design/sfr_ctrl.sv]
// ---------------------------------------------------------------------------
// sfr_ctrl
// frame sequencer: start detect, header and type checks, running checksum
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sum_checked_frame_receiver_macros.svh"

module sfr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte_i,
  input  logic [7:0]        header_i,
  input  logic [7:0]        type_i,
  input  logic [7:0]        byte13_i,
  input  logic              out_busy_i,
  output sfr_pkg::sfr_ctrl_t ctrl_o
);

  import sfr_pkg::*;

  logic             receiving_r, receiving_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       hdr_r, hdr_nxt;
  logic [7:0]       byte1_r, byte1_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             acc;
  logic [7:0]       byte1_now;
  logic [CHK_W-1:0] sum_ext;
  sfr_ctrl_t        ctrl;

  // hold off the closing byte only while an untaken frame sits in the output
  assign in_stall  = out_busy_i && receiving_r && (idx_r == IDX_LAST);
  assign acc       = in_valid && !in_stall;
  assign byte1_now = (idx_r == IDX_FIRST) ? rx_byte_i : byte1_r;
  assign sum_ext   = {{(CHK_W - SUM_W){1'b0}}, sum_r};

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      receiving_r <= receiving_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // frame bytes kept for the checks
  always_ff @(posedge clk) begin
    hdr_r   <= hdr_nxt;
    byte1_r <= byte1_nxt;
    sum_r   <= sum_nxt;
  end

  // next state and beat decode
  always_comb begin
    receiving_nxt = receiving_r;
    idx_nxt       = idx_r;
    hdr_nxt       = hdr_r;
    byte1_nxt     = byte1_r;
    sum_nxt       = sum_r;
    ctrl          = '0;
    if (acc) begin
      if (!receiving_r) begin
        if (rx_byte_i == header_i) begin
          hdr_nxt       = rx_byte_i;
          receiving_nxt = 1'b1;
          idx_nxt       = IDX_FIRST;
        end
      end else begin
        ctrl.shift = 1'b1;
        if (idx_r == IDX_FIRST) begin
          byte1_nxt = rx_byte_i;
        end
        if (hdr_r != header_i || byte1_now != type_i) begin
          // abort, the offending byte does not restart a frame
          receiving_nxt = 1'b0;
          idx_nxt       = '0;
        end else begin
          if (idx_r == IDX_FIRST) begin
            sum_nxt = {{(SUM_W - 8){1'b0}}, rx_byte_i};
          end else if (idx_r <= IDX_SUM) begin
            sum_nxt = sum_r + {{(SUM_W - 8){1'b0}}, rx_byte_i};
          end
          if (idx_r == IDX_LAST) begin
            receiving_nxt = 1'b0;
            idx_nxt       = '0;
            ctrl.emit     = (sum_ext == {byte13_i, rx_byte_i});
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
    end
  end

  assign ctrl_o = ctrl;

  `SFR_ASSERT_NOW(a_idle_idx, clk, rst_n, !receiving_r, idx_r == '0, "idle with nonzero index")
  `SFR_ASSERT_NOW(a_idx_range, clk, rst_n, receiving_r, idx_r >= IDX_FIRST && idx_r <= IDX_LAST, "index out of frame")
  `SFR_ASSERT_NOW(a_emit_last, clk, rst_n, ctrl.emit, receiving_r && idx_r == IDX_LAST && acc, "frame emitted off the closing byte")
  `SFR_ASSERT_NEXT(a_emit_idle, clk, rst_n, ctrl.emit, !receiving_r && idx_r == '0, "receiver not idle after a frame")

endmodule

[design/sum_checked_frame_receiver.sv]
// ---------------------------------------------------------------------------
// sum_checked_frame_receiver
// assembles fixed 15-byte frames and releases the payload of frames whose
// 16-bit additive checksum matches
// ---------------------------------------------------------------------------
// The receiver takes one byte per clock unless it stalls, with no gaps needed
// between bytes or frames: each byte only moves a row of thirteen byte cells
// and updates a small sequencer with a running sum. A good frame appears on
// the output in the cycle after its closing byte, held in an output register.
// The input stalls only on the closing byte of a frame in progress while the
// previous frame still waits in that register; all other bytes are taken
// even then. Frames with a bad type byte or checksum produce no output.
`timescale 1ns / 1ps
`include "sum_checked_frame_receiver_macros.svh"

module sum_checked_frame_receiver (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [7:0]                     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [63:0]                    out_payload_low,
  output logic [23:0]                    out_payload_high
);

  import sfr_pkg::*;

  logic [7:0]  header_r;
  logic [7:0]  type_r;
  logic        out_valid_r;
  logic [63:0] low_r;
  logic [23:0] high_r;
  logic        out_busy;
  byte_row_t   taps;
  sfr_ctrl_t   ctrl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_RST;
      type_r   <= TYPE_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_HEADER: header_r <= cfg_wdata;
        CFG_TYPE:   type_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_busy = out_valid_r && out_stall;

  // sequencer
  sfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte_i  (in_rx_byte),
    .header_i   (header_r),
    .type_i     (type_r),
    .byte13_i   (taps[0]),
    .out_busy_i (out_busy),
    .ctrl_o     (ctrl)
  );

  // byte cell row
  sfr_chain u_chain (
    .clk     (clk),
    .shift_i (ctrl.shift),
    .byte_i  (in_rx_byte),
    .taps_o  (taps)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload capture, byte k of the frame sits in cell 13-k
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      for (int j = 0; j < 8; j++) begin
        low_r[8*j +: 8] <= taps[11 - j];
      end
      for (int j = 0; j < 3; j++) begin
        high_r[8*j +: 8] <= taps[3 - j];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_low  = low_r;
  assign out_payload_high = high_r;

  `SFR_ASSERT_NOW(a_no_overwrite, clk, rst_n, ctrl.emit, !out_busy, "frame emitted over a waiting beat")
  `SFR_ASSERT_NEXT(a_emit_valid, clk, rst_n, ctrl.emit, out_valid_r, "emitted frame not presented")

endmodule

[tb/sv/tb.sv]
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the sum-checked frame receiver: a byte-level
// frame predictor, directed frames, then random frames under several
// register settings and idle patterns on both channels
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sfr_pkg::*;

  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_BYTES = 250;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned SETTLE_CYC  = 4;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [63:0] lo;
    logic [23:0] hi;
  } payload_t;

  typedef enum logic { ROW_BYTES, ROW_CFG } row_kind_t;

  // bytes of a row are written left to right, first byte most significant
  typedef struct {
    row_kind_t        kind;
    cfg_idx_t         idx;
    int unsigned      n;
    logic [14:0][7:0] data;
    bit               typed;
    logic [63:0]      lo;
    logic [23:0]      hi;
  } dir_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  cfg_idx_t    cfg_addr   = CFG_HEADER;
  logic [7:0]  cfg_wdata  = 8'h00;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_stall  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [63:0] out_payload_low;
  logic [23:0] out_payload_high;

  // predictor state and register copies
  logic        rx_receiving = 1'b0;
  logic [3:0]  rx_index     = 4'd0;
  logic [7:0]  rx_store [FRAME_LEN];
  logic [7:0]  reg_header   = HEADER_RST;
  logic [7:0]  reg_type     = TYPE_RST;

  payload_t    payload_q [$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned src_gap_pct  = 0;
  int unsigned rcv_gap_pct  = 0;
  int unsigned phase_bytes  = 0;
  int unsigned hold_left    = 0;
  bit          hold_req     = 1'b0;

  dir_row_t    dir_rows [11];

  sum_checked_frame_receiver dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_payload_low  (out_payload_low),
    .out_payload_high (out_payload_high)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // frame predictor: one received byte in, at most one payload out
  function automatic bit predict_frame_byte(input logic [7:0] b, output logic [63:0] lo,
                                            output logic [23:0] hi);
    logic [15:0] sum;
    int k;
    lo  = '0;
    hi  = '0;
    sum = '0;
    if (!rx_receiving) begin
      if (b == reg_header) begin
        rx_store[0]  = b;
        rx_index     = 4'd1;
        rx_receiving = 1'b1;
      end
      return 1'b0;
    end
    rx_store[rx_index] = b;
    // header and type are checked against the live registers on every beat
    if (rx_store[0] != reg_header || rx_store[1] != reg_type) begin
      rx_index     = 4'd0;
      rx_receiving = 1'b0;
      foreach (rx_store[i]) rx_store[i] = 8'h00;
      return 1'b0;
    end
    rx_index = rx_index + 4'd1;
    if (rx_index < FRAME_LEN) return 1'b0;
    rx_index     = 4'd0;
    rx_receiving = 1'b0;
    for (k = 1; k <= SUM_LAST; k++) sum = sum + 16'(rx_store[k]);
    if ({rx_store[13], rx_store[14]} != sum) begin
      foreach (rx_store[i]) rx_store[i] = 8'h00;
      return 1'b0;
    end
    for (k = 0; k < 8; k++) lo[8*k +: 8] = rx_store[2+k];
    for (k = 0; k < 3; k++) hi[8*k +: 8] = rx_store[10+k];
    return 1'b1;
  endfunction

  // offer one beat, hold it until taken, then log the expected payload
  task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input logic [63:0] tlo = '0, input logic [23:0] thi = '0);
    logic [63:0] plo;
    logic [23:0] phi;
    bit got;
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    got = predict_frame_byte(b, plo, phi);
    if (typed) payload_q.push_back('{lo: tlo, hi: thi});
    else if (got) payload_q.push_back('{lo: plo, hi: phi});
    phase_bytes++;
  endtask

  // stop sending and let every expected payload come out
  task automatic settle_block();
    in_valid <= 1'b0;
    while (payload_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_HEADER) reg_header = val;
    else reg_type = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // payload bytes lean toward the header value and the extremes
  function automatic logic [7:0] pick_data();
    case ($urandom_range(9))
      0: return reg_header;
      1: return 8'h00;
      2: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // good frames mostly, plus bad checksums, bad types, cut frames and noise
  task automatic send_random_frame();
    logic [7:0] fr [FRAME_LEN];
    logic [15:0] sum;
    int unsigned kind, len, k;
    kind = $urandom_range(99);
    if (kind >= 87 && kind < 93) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
      return;
    end
    fr[0] = reg_header;
    fr[1] = reg_type;
    for (k = 2; k <= SUM_LAST; k++) fr[k] = pick_data();
    sum = '0;
    for (k = 1; k <= SUM_LAST; k++) sum = sum + 16'(fr[k]);
    fr[13] = sum[15:8];
    fr[14] = sum[7:0];
    len = FRAME_LEN;
    if (kind >= 70 && kind < 80) fr[13 + $urandom_range(1)] ^= 8'(1 << $urandom_range(7));
    else if (kind >= 80 && kind < 87) fr[1] ^= 8'($urandom_range(1, 255));
    else if (kind >= 93) len = $urandom_range(2, 12);
    for (k = 0; k < len; k++) push_byte(fr[k]);
  endtask

  function automatic void note_mismatch(input string what, input payload_t want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected lo=%h hi=%h, got lo=%h hi=%h", $realtime, what,
               want.lo, want.hi, out_payload_low, out_payload_high);
  endfunction

  // result side: random stall, or one long hold when asked
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_gap_pct);
    end
  end

  // payload check and watchdog
  always @(posedge clk) begin : check_out
    payload_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else if (out_valid && !out_stall) begin
        if (payload_q.size() == 0) begin
          note_mismatch("payload with none expected", '0);
        end else begin
          want = payload_q.pop_front();
          if (want.lo !== out_payload_low) note_mismatch("payload_low", want);
          else if (want.hi !== out_payload_high) note_mismatch("payload_high", want);
        end
      end
    end
  end

  initial begin : stim
    logic [7:0] ph_header [PHASES];
    logic [7:0] ph_type [PHASES];
    int unsigned p, j;
    bit held, paused;

    foreach (rx_store[i]) rx_store[i] = 8'h00;
    ph_header = '{8'hAC, 8'h00, 8'hFF, 8'h00, 8'h00, HEADER_RST};
    ph_type   = '{8'h03, 8'hFF, 8'h00, 8'h00, 8'h00, TYPE_RST};
    ph_header[3] = 8'($urandom_range(255));
    ph_type[3]   = 8'($urandom_range(255));
    ph_header[4] = 8'($urandom_range(255));
    ph_type[4]   = 8'($urandom_range(255));

    dir_rows = '{
      // idle byte that is not a header is dropped
      '{ROW_BYTES, CFG_HEADER, 1, 120'h00, 1'b0, 64'h0, 24'h0},
      // wrong type byte aborts
      '{ROW_BYTES, CFG_HEADER, 2, 120'hAC00, 1'b0, 64'h0, 24'h0},
      // header value as type byte aborts and is not a new start
      '{ROW_BYTES, CFG_HEADER, 2, 120'hACAC, 1'b0, 64'h0, 24'h0},
      '{ROW_BYTES, CFG_HEADER, 1, 120'h03, 1'b0, 64'h0, 24'h0},
      // all-ones payload, largest checksum
      '{ROW_BYTES, CFG_HEADER, 15, 120'hAC03_FFFF_FFFF_FFFF_FFFF_FFFF_FF0A_F8, 1'b1,
        64'hFFFF_FFFF_FFFF_FFFF, 24'hFF_FFFF},
      '{ROW_CFG, CFG_HEADER, 0, 120'h00, 1'b0, 64'h0, 24'h0},
      '{ROW_CFG, CFG_TYPE, 0, 120'h00, 1'b0, 64'h0, 24'h0},
      // all-zero frame, header value inside the data
      '{ROW_BYTES, CFG_HEADER, 15, 120'h0, 1'b1, 64'h0, 24'h0},
      // header register rewritten mid-frame, next beat aborts
      '{ROW_BYTES, CFG_HEADER, 2, 120'h0000, 1'b0, 64'h0, 24'h0},
      '{ROW_CFG, CFG_HEADER, 0, 120'hFF, 1'b0, 64'h0, 24'h0},
      '{ROW_BYTES, CFG_HEADER, 1, 120'h55, 1'b0, 64'h0, 24'h0}
    };

    src_gap_pct = 26;
    rcv_gap_pct = 86;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        settle_block();
        write_reg(dir_rows[r].idx, dir_rows[r].data[0]);
      end else begin
        for (j = 0; j < dir_rows[r].n; j++)
          push_byte(dir_rows[r].data[dir_rows[r].n - 1 - j],
                    dir_rows[r].typed && (j == dir_rows[r].n - 1),
                    dir_rows[r].lo, dir_rows[r].hi);
      end
    end

    // random phases: two per idle pattern
    paused = 1'b0;
    for (p = 0; p < PHASES; p++) begin
      settle_block();
      write_reg(CFG_HEADER, ph_header[p]);
      write_reg(CFG_TYPE, ph_type[p]);
      case (p / 2)
        0: begin src_gap_pct = 26; rcv_gap_pct = 86; end
        1: begin src_gap_pct = 86; rcv_gap_pct = 26; end
        default: begin src_gap_pct = 0; rcv_gap_pct = 0; end
      endcase
      phase_bytes = 0;
      held        = 1'b0;
      while (phase_bytes < PHASE_BYTES) begin
        send_random_frame();
        // one long receiver hold per chosen phase while beats keep coming
        if ((p == 1 || p == 4) && !held && phase_bytes >= 100) begin
          hold_req = 1'b1;
          held     = 1'b1;
        end
        // sender waits for every payload mid-phase
        if (p == 2 && !paused && phase_bytes >= 120) begin
          settle_block();
          paused = 1'b1;
        end
      end
    end

    settle_block();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && payload_q.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
